[rtl/tkd_pkg.sv]
// ----------------------------------------------------------------------------
// tkd_pkg
// Types and constants shared by the terminal key escape decoder.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package tkd_pkg;

    // parser states, one-hot
    typedef enum logic [4:0] {
        ST_IDLE = 5'b00001,
        ST_ESC  = 5'b00010,
        ST_CSI  = 5'b00100,
        ST_CSI2 = 5'b01000,
        ST_ESCO = 5'b10000
    } state_t;

    // event kinds
    localparam logic [1:0] KIND_PLAIN = 2'd0;
    localparam logic [1:0] KIND_META  = 2'd1;
    localparam logic [1:0] KIND_KEY   = 2'd2;

    // byte values
    localparam logic [7:0] CH_ESC    = 8'h1B;
    localparam logic [7:0] CH_LBRACK = 8'h5B;
    localparam logic [7:0] CH_UPPERO = 8'h4F;
    localparam logic [7:0] CH_TILDE  = 8'h7E;
    localparam logic [7:0] CH_ZERO   = 8'h30;
    localparam logic [7:0] CH_NINE   = 8'h39;
    localparam logic [7:0] CH_A      = 8'h41;
    localparam logic [7:0] CH_B      = 8'h42;
    localparam logic [7:0] CH_C      = 8'h43;
    localparam logic [7:0] CH_D      = 8'h44;
    localparam logic [7:0] CH_E      = 8'h45;
    localparam logic [7:0] CH_F      = 8'h46;
    localparam logic [7:0] CH_H      = 8'h48;
    localparam logic [7:0] CH_L      = 8'h4C;
    localparam logic [7:0] CH_P      = 8'h50;
    localparam logic [7:0] CH_Q      = 8'h51;
    localparam logic [7:0] CH_R      = 8'h52;
    localparam logic [7:0] CH_S      = 8'h53;
    localparam logic [7:0] CH_Z      = 8'h5A;
    localparam logic [7:0] CH_LOW_L  = 8'h6C;
    localparam logic [7:0] CH_LOW_T  = 8'h74;
    localparam logic [7:0] CH_LOW_U  = 8'h75;
    localparam logic [7:0] CH_LOW_V  = 8'h76;
    localparam logic [7:0] CH_LOW_W  = 8'h77;
    localparam logic [7:0] CH_LOW_X  = 8'h78;

    // named key ids
    localparam logic [4:0] K_NONE   = 5'd0;
    localparam logic [4:0] K_HOME   = 5'd1;
    localparam logic [4:0] K_INSERT = 5'd2;
    localparam logic [4:0] K_END    = 5'd4;
    localparam logic [4:0] K_F1     = 5'd7;
    localparam logic [4:0] K_F2     = 5'd8;
    localparam logic [4:0] K_F3     = 5'd9;
    localparam logic [4:0] K_F4     = 5'd10;
    localparam logic [4:0] K_F5     = 5'd11;
    localparam logic [4:0] K_F6     = 5'd12;
    localparam logic [4:0] K_F7     = 5'd13;
    localparam logic [4:0] K_F8     = 5'd14;
    localparam logic [4:0] K_F9     = 5'd15;
    localparam logic [4:0] K_F10    = 5'd16;
    localparam logic [4:0] K_UP     = 5'd27;
    localparam logic [4:0] K_DOWN   = 5'd28;
    localparam logic [4:0] K_RIGHT  = 5'd29;
    localparam logic [4:0] K_LEFT   = 5'd30;
    localparam logic [4:0] K_STAB   = 5'd31;

    localparam logic [6:0]  NUM_MAX      = 7'd127;
    localparam logic [6:0]  TILDE_ENTRIES = 7'd35;

    // one decode step: next parser state and the event it yields
    typedef struct packed {
        state_t      state_next;
        logic [6:0]  num_next;
        logic        emit;
        logic [1:0]  kind;
        logic [7:0]  chr;
        logic [4:0]  key;
    } dec_t;

    // csi <n> '~' table, entries beyond the table read as none
    function automatic logic [4:0] tilde_key(input logic [6:0] n);
        logic [4:0] k;
        unique case (n)
            7'd1:    k = 5'd1;
            7'd2:    k = 5'd2;
            7'd3:    k = 5'd3;
            7'd4:    k = 5'd4;
            7'd5:    k = 5'd5;
            7'd6:    k = 5'd6;
            7'd11:   k = 5'd7;
            7'd12:   k = 5'd8;
            7'd13:   k = 5'd9;
            7'd14:   k = 5'd10;
            7'd15:   k = 5'd11;
            7'd17:   k = 5'd12;
            7'd18:   k = 5'd13;
            7'd19:   k = 5'd14;
            7'd20:   k = 5'd15;
            7'd21:   k = 5'd16;
            7'd23:   k = 5'd17;
            7'd24:   k = 5'd18;
            7'd25:   k = 5'd19;
            7'd26:   k = 5'd20;
            7'd28:   k = 5'd21;
            7'd29:   k = 5'd22;
            7'd31:   k = 5'd23;
            7'd32:   k = 5'd24;
            7'd33:   k = 5'd25;
            7'd34:   k = 5'd26;
            default: k = K_NONE;
        endcase
        return k;
    endfunction

endpackage

[rtl/tkd_decode.sv]
// ----------------------------------------------------------------------------
// tkd_decode
// Combinational escape parser step: one byte against the current state.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tkd_decode
(
    input  tkd_pkg::state_t     state,
    input  logic [6:0]          num,
    input  logic [7:0]          in_byte,
    output tkd_pkg::dec_t       dec
);
    import tkd_pkg::*;

    logic        is_digit;
    logic [3:0]  digit;
    logic [10:0] num_mac;
    logic [6:0]  num_sat;

    assign is_digit = (in_byte >= CH_ZERO) && (in_byte <= CH_NINE);
    assign digit    = in_byte[3:0];

    // n*10 + digit as (n<<3) + (n<<1) + digit
    assign num_mac = {1'b0, num, 3'b000} + {3'b000, num, 1'b0} + {7'd0, digit};
    assign num_sat = (num_mac > {4'd0, NUM_MAX}) ? NUM_MAX : num_mac[6:0];

    always_comb
    begin
        dec.state_next = ST_IDLE;
        dec.num_next   = num;
        dec.emit       = 1'b0;
        dec.kind       = KIND_KEY;
        dec.chr        = 8'd0;
        dec.key        = K_NONE;

        unique case (state)
            ST_ESC:
            begin
                if (in_byte == CH_ESC)
                begin
                    dec.state_next = ST_ESC;
                    dec.emit       = 1'b1;
                    dec.kind       = KIND_PLAIN;
                    dec.chr        = in_byte;
                end
                else if (in_byte == CH_LBRACK)
                begin
                    dec.state_next = ST_CSI;
                    dec.num_next   = 7'd0;
                end
                else if (in_byte == CH_UPPERO)
                begin
                    dec.state_next = ST_ESCO;
                end
                else
                begin
                    dec.emit = 1'b1;
                    dec.kind = KIND_META;
                    dec.chr  = in_byte;
                end
            end

            ST_CSI:
            begin
                if (is_digit)
                begin
                    dec.state_next = ST_CSI;
                    dec.num_next   = num_sat;
                end
                else
                begin
                    dec.emit = 1'b1;
                    unique case (in_byte)
                        CH_LBRACK:
                        begin
                            dec.state_next = ST_CSI2;
                            dec.emit       = 1'b0;
                        end
                        CH_TILDE:
                        begin
                            dec.emit = (num < TILDE_ENTRIES);
                            dec.key  = tilde_key(num);
                        end
                        CH_A:    dec.key  = K_UP;
                        CH_B:    dec.key  = K_DOWN;
                        CH_C:    dec.key  = K_RIGHT;
                        CH_D:    dec.key  = K_LEFT;
                        CH_F:    dec.key  = K_END;
                        CH_H:    dec.key  = K_HOME;
                        CH_L:    dec.key  = K_INSERT;
                        CH_Z:    dec.key  = K_STAB;
                        default: dec.emit = 1'b0;
                    endcase
                end
            end

            ST_CSI2:
            begin
                dec.emit = 1'b1;
                unique case (in_byte)
                    CH_A:    dec.key  = K_F1;
                    CH_B:    dec.key  = K_F2;
                    CH_C:    dec.key  = K_F3;
                    CH_D:    dec.key  = K_F4;
                    CH_E:    dec.key  = K_F5;
                    default: dec.emit = 1'b0;
                endcase
            end

            ST_ESCO:
            begin
                dec.emit = 1'b1;
                unique case (in_byte)
                    CH_A:     dec.key  = K_UP;
                    CH_B:     dec.key  = K_DOWN;
                    CH_C:     dec.key  = K_RIGHT;
                    CH_D:     dec.key  = K_LEFT;
                    CH_P:     dec.key  = K_F1;
                    CH_Q:     dec.key  = K_F2;
                    CH_R:     dec.key  = K_F3;
                    CH_S:     dec.key  = K_F4;
                    CH_LOW_T: dec.key  = K_F5;
                    CH_LOW_U: dec.key  = K_F6;
                    CH_LOW_V: dec.key  = K_F7;
                    CH_LOW_L: dec.key  = K_F8;
                    CH_LOW_W: dec.key  = K_F9;
                    CH_LOW_X: dec.key  = K_F10;
                    default:  dec.emit = 1'b0;
                endcase
            end

            // idle, and any code that is not a legal state
            default:
            begin
                if (in_byte == CH_ESC)
                begin
                    dec.state_next = ST_ESC;
                end
                else
                begin
                    dec.emit = 1'b1;
                    dec.kind = KIND_PLAIN;
                    dec.chr  = in_byte;
                end
            end
        endcase
    end

endmodule

[rtl/terminal_key_escape_decoder_core.sv]
// ----------------------------------------------------------------------------
// terminal_key_escape_decoder_core
// Turns the terminal keyboard byte stream into plain, meta and named key events.
// ----------------------------------------------------------------------------
// Usage:
//   in channel  : in_valid / in_ready / in_byte, one terminal byte per request.
//   out channel : out_valid / out_ready / key_kind, char_value, named_key,
//                 one key event per request.
//   Each byte yields zero or one event. Bytes that only advance the escape
//   parser (ESC, '[', 'O', csi digits, dropped finals) produce no request.
//   Each accepted byte lands in the input register; from there it is parsed
//   into the result register, which carries its event to the out channel.
//   Throughput: one byte per cycle while the out channel is not stalled; the
//   parse state and the saturating csi parameter update in the same cycle the
//   byte leaves the input register.
//   Stall: while out_valid is high and out_ready low, the result holds, and
//   one more byte may sit in the input register; in_ready drops only when
//   both are full.
//   Reset: rst_n clears the parser to idle, the csi parameter to zero and
//   both pipeline stages to empty.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module terminal_key_escape_decoder_core
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [7:0]  in_byte,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [1:0]  key_kind,
    output logic [7:0]  char_value,
    output logic [4:0]  named_key
);
    import tkd_pkg::*;

    logic        s1_valid_reg;
    logic [7:0]  s1_byte_reg;
    state_t      state_reg;
    logic [6:0]  num_reg;
    logic        out_valid_reg;
    logic [1:0]  kind_reg;
    logic [7:0]  chr_reg;
    logic [4:0]  key_reg;

    logic        out_free;
    logic        step;
    logic        in_fire;
    dec_t        dec;

    assign out_free = !out_valid_reg || out_ready;
    assign step     = s1_valid_reg && out_free;
    assign in_ready = !s1_valid_reg || out_free;
    assign in_fire  = in_valid && in_ready;

    tkd_decode u_decode
    (
        .state   (state_reg),
        .num     (num_reg),
        .in_byte (s1_byte_reg),
        .dec     (dec)
    );

    // input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            s1_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            s1_byte_reg <= in_byte;
        end
    end

    // parser state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            num_reg   <= 7'd0;
        end
        else if (step)
        begin
            state_reg <= dec.state_next;
            num_reg   <= dec.num_next;
        end
    end

    // result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (out_free)
        begin
            out_valid_reg <= step && dec.emit;
        end
    end

    always_ff @(posedge clk)
    begin
        if (step && dec.emit)
        begin
            kind_reg <= dec.kind;
            chr_reg  <= dec.chr;
            key_reg  <= dec.key;
        end
    end

    assign out_valid  = out_valid_reg;
    assign key_kind   = kind_reg;
    assign char_value = chr_reg;
    assign named_key  = key_reg;

`ifndef ASSERT_OFF
    a_key_no_char: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && kind_reg == KIND_KEY) |-> chr_reg == 8'd0)
        else $error("named key event carries a nonzero byte");

    a_char_no_key: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && kind_reg != KIND_KEY) |-> key_reg == K_NONE)
        else $error("byte event carries a named key id");

    a_kind_legal: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> (kind_reg == KIND_PLAIN || kind_reg == KIND_META ||
                           kind_reg == KIND_KEY))
        else $error("illegal event kind");

    a_s1_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (s1_valid_reg && out_valid_reg && !out_ready) |=>
            (s1_valid_reg && $stable(s1_byte_reg) && $stable(state_reg)))
        else $error("pending byte or parser state changed during stall");
`endif

endmodule
